>>> sv/clsu_pkg.sv
// clsu_pkg: shared codes, types and decode helpers for the checked load/store unit
// used by checked_load_store_unit_core; no dependencies

package clsu_pkg;

  localparam int unsigned MEM_WORDS_DEF = 262144;

  typedef logic [3:0]  func_t;
  typedef logic [2:0]  status_t;
  typedef logic [2:0]  reg_idx_t;
  typedef logic [31:0] word_t;

  // access size as log2 of its byte count
  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2
  } size_t;

  localparam func_t FN_LD_I8  = 4'd0;
  localparam func_t FN_LD_I16 = 4'd1;
  localparam func_t FN_LD_I32 = 4'd2;
  localparam func_t FN_LD_U8  = 4'd3;
  localparam func_t FN_LD_U16 = 4'd4;
  localparam func_t FN_LD_U32 = 4'd5;
  localparam func_t FN_ST_U8  = 4'd6;
  localparam func_t FN_ST_U16 = 4'd7;
  localparam func_t FN_ST_U32 = 4'd8;

  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_LD_MISALIGN = 3'd1;
  localparam status_t ST_LD_OOB      = 3'd2;
  localparam status_t ST_ST_MISALIGN = 3'd3;
  localparam status_t ST_ST_OOB      = 3'd4;

  localparam reg_idx_t REG_DATA_LOW   = 3'd0;
  localparam reg_idx_t REG_DATA_HIGH  = 3'd1;
  localparam reg_idx_t REG_HEAP_LOW   = 3'd2;
  localparam reg_idx_t REG_HEAP_HIGH  = 3'd3;
  localparam reg_idx_t REG_STACK_LOW  = 3'd4;
  localparam reg_idx_t REG_STACK_HIGH = 3'd5;

  function automatic size_t func_size(input func_t func);
    size_t sz;
    unique case (func)
      FN_LD_I8, FN_LD_U8, FN_ST_U8:    sz = SZ_BYTE;
      FN_LD_I16, FN_LD_U16, FN_ST_U16: sz = SZ_HALF;
      default:                         sz = SZ_WORD;
    endcase
    return sz;
  endfunction

  // whole access [addr, addr_end) inside [low, high)
  function automatic logic region_fits(input word_t low, input word_t high,
                                       input word_t addr, input logic [32:0] addr_end);
    return (low <= addr) && (addr_end <= {1'b0, high});
  endfunction

endpackage

>>> sv/checked_load_store_unit_core.sv
// checked_load_store_unit_core: bounds-checked load/store port over one word memory
// depends on clsu_pkg

// Each transfer on the in_ channel is one load or store of 1, 2 or 4 bytes; exactly one
// result leaves on the out_ channel, in order. Misalignment is checked first, then the
// data, heap and stack regions (cfg_ registers 0 to 5). The backing store is a single
// synchronous memory of MEM_WORDS 32-bit words, little-endian, byte address a in word
// (a >> 2) mod MEM_WORDS. After reset a clearing pass zeroes the memory, one word per
// cycle, over all MEM_WORDS words; no item is taken meanwhile, configuration writes are.
// An item is handled by one sequencer that reads the word, then merges or extracts it,
// so items do not overlap. A good access passes the check, read, merge and result
// states when MEM_WORDS is a power of two; otherwise the word index comes from a
// reciprocal multiply, a multiply-subtract and one correction step before the read.
// A rejected or unused-code item goes from check straight to the result state. While
// out_stall holds the previous result, the finished item waits and no new item is taken.

module checked_load_store_unit_core
  import clsu_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,

  input  logic     in_valid,
  output logic     in_stall,
  input  func_t    in_func,
  input  word_t    in_address,
  input  word_t    in_store_data,

  output logic     out_valid,
  input  logic     out_stall,
  output word_t    out_load_data,
  output status_t  out_status,

  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  reg_idx_t cfg_index,
  input  word_t    cfg_data
);

  localparam int unsigned IDX_W    = $clog2(MEM_WORDS);
  localparam logic        IS_POW2  = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);
  localparam logic [29:0] MEM_WORDS_C = 30'(MEM_WORDS);
  localparam logic [20:0] RECIP_C  = 21'((64'd1 << 30) / MEM_WORDS);
  localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(MEM_WORDS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_REM,
    S_FIX,
    S_READ,
    S_MERGE,
    S_FIN
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] clr_idx_r;
  func_t            func_r;
  word_t            addr_r;
  word_t            sdata_r;
  size_t            size_r;
  logic             store_r;
  logic             signed_r;
  logic [29:0]      rem_r;
  logic [20:0]      quo_r;
  word_t            res_data_r;
  status_t          res_status_r;
  logic             out_valid_r;
  word_t            out_data_r;
  status_t          out_status_r;

  word_t data_low_r, data_high_r, heap_low_r, heap_high_r, stack_low_r, stack_high_r;

  // memory
  logic [31:0]      mem [MEM_WORDS];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  word_t            mem_wdata;
  logic             mem_re;
  word_t            mem_rdata_r;

  // check stage
  size_t        chk_size;
  logic         chk_store;
  logic         chk_misalign;
  logic [32:0]  chk_end;
  logic         chk_fits;
  status_t      chk_status;

  // word index reduction
  logic [50:0]  quo_prod;
  logic [29:0]  quo_mul;

  // merge stage
  logic [4:0]   shamt;
  word_t        rd_shift;
  word_t        ld_value;
  word_t        st_shift;
  logic [3:0]   byte_en;
  word_t        st_word;

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_load_data = out_data_r;
  assign out_status    = out_status_r;
  assign cfg_ready     = 1'b1;

  assign quo_prod = {21'b0, addr_r[31:2]} * {30'b0, RECIP_C};
  assign quo_mul  = {9'b0, quo_r} * MEM_WORDS_C;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_low_r   <= '0;
      data_high_r  <= '0;
      heap_low_r   <= '0;
      heap_high_r  <= '0;
      stack_low_r  <= '0;
      stack_high_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DATA_LOW:   data_low_r   <= cfg_data;
        REG_DATA_HIGH:  data_high_r  <= cfg_data;
        REG_HEAP_LOW:   heap_low_r   <= cfg_data;
        REG_HEAP_HIGH:  heap_high_r  <= cfg_data;
        REG_STACK_LOW:  stack_low_r  <= cfg_data;
        REG_STACK_HIGH: stack_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // alignment and region check on the latched item
  always_comb begin
    chk_size  = func_size(func_r);
    chk_store = (func_r >= FN_ST_U8);
    unique case (chk_size)
      SZ_BYTE: chk_misalign = 1'b0;
      SZ_HALF: chk_misalign = addr_r[0];
      default: chk_misalign = (addr_r[1:0] != 2'b00);
    endcase
    chk_end  = {1'b0, addr_r} + (33'd1 << chk_size);
    chk_fits = region_fits(data_low_r, data_high_r, addr_r, chk_end) ||
               region_fits(heap_low_r, heap_high_r, addr_r, chk_end) ||
               region_fits(stack_low_r, stack_high_r, addr_r, chk_end);
    priority if (func_r > FN_ST_U32) begin
      chk_status = ST_OK;
    end else if (chk_misalign) begin
      chk_status = chk_store ? ST_ST_MISALIGN : ST_LD_MISALIGN;
    end else if (!chk_fits) begin
      chk_status = chk_store ? ST_ST_OOB : ST_LD_OOB;
    end else begin
      chk_status = ST_OK;
    end
  end

  // load extraction and store merge on the read word
  always_comb begin
    shamt    = {addr_r[1:0], 3'b000};
    rd_shift = mem_rdata_r >> shamt;
    unique case (size_r)
      SZ_BYTE: ld_value = signed_r ? {{24{rd_shift[7]}}, rd_shift[7:0]}
                                   : {24'b0, rd_shift[7:0]};
      SZ_HALF: ld_value = signed_r ? {{16{rd_shift[15]}}, rd_shift[15:0]}
                                   : {16'b0, rd_shift[15:0]};
      default: ld_value = rd_shift;
    endcase
    st_shift = sdata_r << shamt;
    unique case (size_r)
      SZ_BYTE: byte_en = 4'b0001 << addr_r[1:0];
      SZ_HALF: byte_en = 4'b0011 << addr_r[1:0];
      default: byte_en = 4'b1111;
    endcase
    for (int b = 0; b < 4; b++) begin
      st_word[b*8 +: 8] = byte_en[b] ? st_shift[b*8 +: 8] : mem_rdata_r[b*8 +: 8];
    end
  end

  always_comb begin
    mem_re    = (state_r == S_READ);
    mem_we    = (state_r == S_CLEAR) || ((state_r == S_MERGE) && store_r);
    mem_waddr = (state_r == S_CLEAR) ? clr_idx_r : rem_r[IDX_W-1:0];
    mem_wdata = (state_r == S_CLEAR) ? '0 : st_word;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[rem_r[IDX_W-1:0]];
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == CLR_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            func_r  <= in_func;
            addr_r  <= in_address;
            sdata_r <= in_store_data;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          size_r       <= chk_size;
          store_r      <= chk_store;
          signed_r     <= (func_r <= FN_LD_I32);
          rem_r        <= addr_r[31:2];
          quo_r        <= quo_prod[50:30];
          res_data_r   <= '0;
          res_status_r <= chk_status;
          if (func_r > FN_ST_U32 || chk_status != ST_OK) begin
            state_r <= S_FIN;
          end else if (IS_POW2) begin
            state_r <= S_READ;
          end else begin
            state_r <= S_REM;
          end
        end
        S_REM: begin
          rem_r   <= rem_r - quo_mul;
          state_r <= S_FIX;
        end
        S_FIX: begin
          if (rem_r >= MEM_WORDS_C) begin
            rem_r <= rem_r - MEM_WORDS_C;
          end
          state_r <= S_READ;
        end
        S_READ: begin
          state_r <= S_MERGE;
        end
        S_MERGE: begin
          if (!store_r) begin
            res_data_r <= ld_value;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_data_r   <= res_data_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
